@@ rtl/sha256_stream_hasher_top_assert.svh @@
// Assertion macros for the SHA-256 stream hasher.
// Each macro expects clk and arst_n in scope.
`ifndef SHA256_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA256_STREAM_HASHER_TOP_ASSERT_SVH

// Same-cycle implication.
`define SHS_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("shs assertion failed");

// Next-cycle implication.
`define SHS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("shs assertion failed");

`endif

@@ rtl/shs_pkg.sv @@
`default_nettype none
package shs_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MARK,
		ST_ZERO,
		ST_LEN,
		ST_INIT,
		ST_ROUND,
		ST_FOLD,
		ST_DIGEST
	} state_t;

	typedef enum logic [1:0] {
		SRC_IN,
		SRC_MARK,
		SRC_ZERO,
		SRC_LEN
	} byte_src_t;

	typedef struct packed {
		logic      push;
		byte_src_t src;
		logic      count;
		logic      load_work;
		logic      round;
		logic      fold;
		logic      load_digest;
	} cmd_t;

	typedef struct packed {
		logic fill_last;
		logic fill_56;
		logic round_last;
		logic out_busy;
	} stat_t;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_START = 6'd56;

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage
`default_nettype wire

@@ rtl/shs_if.sv @@
`default_nettype none
interface shs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       msg_end;

	modport source (output valid, output data_byte, output byte_valid, output msg_end,
		input ready);
	modport sink (input valid, input data_byte, input byte_valid, input msg_end,
		output ready);
endinterface

interface shs_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        final_word;

	modport source (output valid, output digest_word, output word_index,
		output final_word, input ready);
	modport sink (input valid, input digest_word, input word_index,
		input final_word, output ready);
endinterface
`default_nettype wire

@@ rtl/shs_datapath.sv @@
`default_nettype none
module shs_datapath
	import shs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output stat_t            stat,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             final_word
);

	function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// The 16-word window is both the block buffer and the message schedule:
	// bytes shift in at the bottom, and each round shifts in one new word.
	logic [511:0] win_q;
	logic [5:0]   fill_q;
	logic [63:0]  total_q;
	logic [31:0]  chain_q [8];
	logic [31:0]  v_q [8];
	logic [5:0]   round_q;
	logic [31:0]  dig_q [8];
	logic         busy_q;
	logic [2:0]   idx_q;

	logic [63:0]  bit_len;
	logic [63:0]  len_shift;
	logic [7:0]   push_byte;
	logic [31:0]  w0, w1, w9, w14, w_new;
	logic [31:0]  s0, s1, big0, big1, ch, maj, t1, t2;

	always_comb begin
		bit_len   = {total_q[60:0], 3'b000};
		len_shift = bit_len << {fill_q[2:0], 3'b000};
		case (cmd.src)
			SRC_IN:   push_byte = data_byte;
			SRC_MARK: push_byte = PAD_MARK;
			SRC_ZERO: push_byte = 8'h00;
			SRC_LEN:  push_byte = len_shift[63:56];
			default:  push_byte = 8'h00;
		endcase
	end

	always_comb begin
		w0    = win_q[511:480];
		w1    = win_q[479:448];
		w9    = win_q[223:192];
		w14   = win_q[63:32];
		s0    = ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3);
		s1    = ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10);
		w_new = w0 + s0 + w9 + s1;
		big1  = ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25);
		ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1    = v_q[7] + big1 + ch + ROUND_K[round_q] + w0;
		big0  = ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22);
		maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2    = big0 + maj;
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			win_q <= {win_q[503:0], push_byte};
		end else if (cmd.round) begin
			win_q <= {win_q[479:0], w_new};
		end
		if (cmd.load_work) begin
			v_q <= chain_q;
		end else if (cmd.round) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end
		if (cmd.load_digest) begin
			dig_q <= chain_q;
		end else if (busy_q && out_ready) begin
			for (int i = 0; i < 7; i++) begin
				dig_q[i] <= dig_q[i + 1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			total_q <= '0;
			chain_q <= INIT_H;
			round_q <= '0;
			busy_q  <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (cmd.load_digest) begin
				fill_q  <= '0;
				total_q <= '0;
				chain_q <= INIT_H;
			end else begin
				if (cmd.push) begin
					fill_q <= fill_q + 6'd1;
				end
				if (cmd.count) begin
					total_q <= total_q + 64'd1;
				end
				if (cmd.fold) begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + v_q[i];
					end
				end
			end
			if (cmd.load_work) begin
				round_q <= '0;
			end else if (cmd.round) begin
				round_q <= round_q + 6'd1;
			end
			if (cmd.load_digest) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q && out_ready) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == 3'd7) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_comb begin
		stat.fill_last  = (fill_q == 6'd63);
		stat.fill_56    = (fill_q == LEN_START);
		stat.round_last = (round_q == 6'd63);
		stat.out_busy   = busy_q;
		out_valid       = busy_q;
		digest_word     = dig_q[0];
		word_index      = idx_q;
		final_word      = (idx_q == 3'd7);
	end

endmodule
`default_nettype wire

@@ rtl/shs_controller.sv @@
`default_nettype none
module shs_controller
	import shs_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire logic  byte_valid,
	input  wire logic  msg_end,
	output logic       in_ready,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	state_t state_q, state_d;
	state_t ret_q, ret_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ret_d    = ret_q;
		cmd      = '0;
		cmd.src  = SRC_IN;
		in_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.push  = byte_valid;
					cmd.count = byte_valid;
					if (byte_valid && stat.fill_last) begin
						state_d = ST_INIT;
						ret_d   = msg_end ? ST_MARK : ST_IDLE;
					end else if (msg_end) begin
						state_d = ST_MARK;
					end
				end
			end
			ST_MARK: begin
				cmd.push = 1'b1;
				cmd.src  = SRC_MARK;
				if (stat.fill_last) begin
					state_d = ST_INIT;
					ret_d   = ST_ZERO;
				end else begin
					state_d = ST_ZERO;
				end
			end
			ST_ZERO: begin
				if (stat.fill_56) begin
					state_d = ST_LEN;
				end else begin
					cmd.push = 1'b1;
					cmd.src  = SRC_ZERO;
					if (stat.fill_last) begin
						state_d = ST_INIT;
						ret_d   = ST_ZERO;
					end
				end
			end
			ST_LEN: begin
				cmd.push = 1'b1;
				cmd.src  = SRC_LEN;
				if (stat.fill_last) begin
					state_d = ST_INIT;
					ret_d   = ST_DIGEST;
				end
			end
			ST_INIT: begin
				cmd.load_work = 1'b1;
				state_d       = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				if (stat.round_last) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				state_d  = ret_q;
			end
			ST_DIGEST: begin
				// The previous digest must have drained before this one is loaded.
				if (!stat.out_busy) begin
					cmd.load_digest = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/sha256_stream_hasher_top.sv @@
// SHA-256 stream hasher.
// byte_ch takes one word per handshake: a message byte (data_byte, valid
// when byte_valid is set) and msg_end, which closes the message. A word
// with msg_end and no byte closes the message without adding a byte.
// digest_ch gives the digest as eight 32-bit words, word_index 0 first,
// with final_word set on the eighth.
// A data word without msg_end that does not fill the block leaves byte_ch
// ready for the next word. The word that completes a 64-byte block is
// followed by a compression (load, 64 rounds at one round per cycle, chain
// update) in which byte_ch is not ready. After an end word the pad bytes
// are shifted in one per cycle between compressions (one or two of them),
// and the first digest word shows after the last compression, later only
// if the previous digest is still waiting in the output buffer.
// The digest is copied to an output buffer, so byte_ch takes the next
// message while digest_ch is stalled; a later digest waits only until the
// buffer has drained. Reset loads the initial hash values and clears the
// byte count and the output buffer.
`default_nettype none
module sha256_stream_hasher_top
	import shs_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	shs_in_if.sink   byte_ch,
	shs_out_if.source digest_ch
);

	`include "sha256_stream_hasher_top_assert.svh"

	cmd_t  ctl_cmd;
	stat_t dp_stat;
	logic  in_ready;

	shs_controller u_ctl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (byte_ch.valid),
		.byte_valid (byte_ch.byte_valid),
		.msg_end    (byte_ch.msg_end),
		.in_ready   (in_ready),
		.stat       (dp_stat),
		.cmd        (ctl_cmd)
	);

	shs_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (ctl_cmd),
		.stat        (dp_stat),
		.data_byte   (byte_ch.data_byte),
		.out_valid   (digest_ch.valid),
		.out_ready   (digest_ch.ready),
		.digest_word (digest_ch.digest_word),
		.word_index  (digest_ch.word_index),
		.final_word  (digest_ch.final_word)
	);

	assign byte_ch.ready = in_ready;

	// An end word always leads into padding.
	`SHS_ASSERT_NEXT(a_end_pads, byte_ch.valid && byte_ch.ready && byte_ch.msg_end, !byte_ch.ready)
	// After the last digest word is taken, the buffer is empty.
	`SHS_ASSERT_NEXT(a_final_drains, digest_ch.valid && digest_ch.ready && digest_ch.final_word, !digest_ch.valid)
	// A digest is never loaded over one still waiting.
	`SHS_ASSERT_IMPLY(a_no_overwrite, ctl_cmd.load_digest, !digest_ch.valid)

endmodule
`default_nettype wire
